>>> hdl/i2cm_seq_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
package i2cm_seq_pkg;

    localparam int INDEX_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int SADDR_W    = 7;
    localparam int LENGTH_W   = 5;
    localparam int BIDX_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDRESS   = 2'd0,
        CFG_DIRECTION       = 2'd1,
        CFG_TRANSFER_LENGTH = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  wr_data;
    } mem_req_t;

    typedef struct packed {
        logic              send_valid;
        logic              send_from_mem;
        logic [BYTE_W-1:0] send_byte;
        logic              readout_from_mem;
        logic              request_start;
        logic              request_stop;
        logic              ack_enable;
        logic              receive_done;
        logic              transmit_done;
        logic              nack_error;
    } res_t;

endpackage

>>> hdl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer top level: control, byte buffer RAM and output pipeline.
// Pipeline: an input transfer passes the buffer read stage and then the output register to the result.
// Throughput: one item per cycle if out_stall is low; single port: one read or write per item.
// Reset: async active low; index 0, ack enable 1, done/error flags 0, config registers 0.
// Buffer contents are not cleared by reset and are undefined until written.
module i2c_master_transfer_sequencer #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            cmd,
    input  logic [i2cm_seq_pkg::BIDX_W-1:0]       buffer_index,
    input  logic [i2cm_seq_pkg::BYTE_W-1:0]       load_value,
    input  logic                                  start_sent,
    input  logic                                  address_acked,
    input  logic                                  receive_full,
    input  logic                                  transmit_empty,
    input  logic                                  nack_seen,
    input  logic [i2cm_seq_pkg::BYTE_W-1:0]       received_byte,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  send_valid,
    output logic [i2cm_seq_pkg::BYTE_W-1:0]       send_byte,
    output logic                                  request_start,
    output logic                                  request_stop,
    output logic                                  ack_enable,
    output logic                                  receive_done,
    output logic                                  transmit_done,
    output logic                                  nack_error,
    output logic [i2cm_seq_pkg::BYTE_W-1:0]       readout_byte,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [i2cm_seq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cm_seq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    i2cm_seq_pkg::mem_req_t              mem_req;
    i2cm_seq_pkg::res_t                  res;
    i2cm_seq_pkg::res_t                  s1_res_reg;
    logic                                s1_valid_reg;
    logic                                s1_move;
    logic                                accept;
    logic [i2cm_seq_pkg::BYTE_W-1:0]     rd_data;

    logic                                out_valid_reg;
    logic                                send_valid_reg;
    logic [i2cm_seq_pkg::BYTE_W-1:0]     send_byte_reg;
    logic                                request_start_reg;
    logic                                request_stop_reg;
    logic                                ack_enable_reg;
    logic                                receive_done_reg;
    logic                                transmit_done_reg;
    logic                                nack_error_reg;
    logic [i2cm_seq_pkg::BYTE_W-1:0]     readout_byte_reg;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    i2cm_seq_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .cmd            (cmd),
        .buffer_index   (buffer_index),
        .load_value     (load_value),
        .start_sent     (start_sent),
        .address_acked  (address_acked),
        .receive_full   (receive_full),
        .transmit_empty (transmit_empty),
        .nack_seen      (nack_seen),
        .received_byte  (received_byte),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mem_req        (mem_req),
        .res            (res)
    );

    i2cm_seq_buffer #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (accept && mem_req.wr_en),
        .rd_en   (accept && mem_req.rd_en),
        .addr    (mem_req.idx[AW-1:0]),
        .wr_data (mem_req.wr_data),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res;
        end
        if (s1_move)
        begin
            send_valid_reg    <= s1_res_reg.send_valid;
            send_byte_reg     <= s1_res_reg.send_from_mem ? rd_data : s1_res_reg.send_byte;
            request_start_reg <= s1_res_reg.request_start;
            request_stop_reg  <= s1_res_reg.request_stop;
            ack_enable_reg    <= s1_res_reg.ack_enable;
            receive_done_reg  <= s1_res_reg.receive_done;
            transmit_done_reg <= s1_res_reg.transmit_done;
            nack_error_reg    <= s1_res_reg.nack_error;
            readout_byte_reg  <= s1_res_reg.readout_from_mem ? rd_data : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_valid    = send_valid_reg;
    assign send_byte     = send_byte_reg;
    assign request_start = request_start_reg;
    assign request_stop  = request_stop_reg;
    assign ack_enable    = ack_enable_reg;
    assign receive_done  = receive_done_reg;
    assign transmit_done = transmit_done_reg;
    assign nack_error    = nack_error_reg;
    assign readout_byte  = readout_byte_reg;

endmodule

>>> hdl/i2cm_seq_buffer.sv
// Byte buffer: single-port synchronous RAM with registered read data.
module i2cm_seq_buffer #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     addr,
    input  logic [i2cm_seq_pkg::BYTE_W-1:0]   wr_data,
    output logic [i2cm_seq_pkg::BYTE_W-1:0]   rd_data
);

    logic [i2cm_seq_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [i2cm_seq_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/i2cm_seq_ctrl.sv
// Command decode, bus event sequencing, configuration and index/flag state.
module i2cm_seq_ctrl #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [1:0]                            cmd,
    input  logic [i2cm_seq_pkg::BIDX_W-1:0]       buffer_index,
    input  logic [i2cm_seq_pkg::BYTE_W-1:0]       load_value,
    input  logic                                  start_sent,
    input  logic                                  address_acked,
    input  logic                                  receive_full,
    input  logic                                  transmit_empty,
    input  logic                                  nack_seen,
    input  logic [i2cm_seq_pkg::BYTE_W-1:0]       received_byte,
    input  logic                                  cfg_write,
    input  logic [i2cm_seq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i2cm_seq_pkg::CFG_DATA_W-1:0]   cfg_data,
    output i2cm_seq_pkg::mem_req_t                mem_req,
    output i2cm_seq_pkg::res_t                    res
);

    localparam int IW = i2cm_seq_pkg::INDEX_W;
    localparam logic [IW:0] DEPTH_LIM = (IW+1)'(BUFFER_DEPTH);

    logic [IW-1:0]                       index_reg, index_next;
    logic                                ack_reg, ack_next;
    logic                                rx_done_reg, rx_done_next;
    logic                                tx_done_reg, tx_done_next;
    logic                                err_reg, err_next;
    logic [i2cm_seq_pkg::SADDR_W-1:0]    slave_address_reg;
    logic                                direction_reg;
    logic [i2cm_seq_pkg::LENGTH_W-1:0]   length_reg;

    logic [IW-1:0] index_adv;
    logic [IW-1:0] bidx_ext;
    logic          index_in_range;
    logic          bidx_in_range;
    logic          rx_last;

    assign index_adv      = (index_reg == i2cm_seq_pkg::INDEX_MAX) ? index_reg
                                                                    : index_reg + 1'b1;
    assign bidx_ext       = IW'(buffer_index);
    assign index_in_range = {1'b0, index_reg} < DEPTH_LIM;
    assign bidx_in_range  = {1'b0, bidx_ext} < DEPTH_LIM;
    assign rx_last        = ((IW+1)'(index_adv) + (IW+1)'(1)) == (IW+1)'(length_reg);

    always_comb
    begin
        index_next   = index_reg;
        ack_next     = ack_reg;
        rx_done_next = rx_done_reg;
        tx_done_next = tx_done_reg;
        err_next     = err_reg;
        mem_req      = '0;
        res          = '0;
        unique case (i2cm_seq_pkg::cmd_t'(cmd))
            i2cm_seq_pkg::CMD_LOAD:
            begin
                mem_req.wr_en   = bidx_in_range;
                mem_req.idx     = bidx_ext;
                mem_req.wr_data = load_value;
            end
            i2cm_seq_pkg::CMD_START:
            begin
                index_next = '0;
                err_next   = 1'b0;
                if (direction_reg)
                begin
                    rx_done_next = 1'b0;
                    ack_next     = 1'b1;
                end
                else
                begin
                    tx_done_next = 1'b0;
                end
                res.request_start = 1'b1;
            end
            i2cm_seq_pkg::CMD_EVENT:
            begin
                if (start_sent)
                begin
                    res.send_valid = 1'b1;
                    res.send_byte  = {slave_address_reg, direction_reg};
                end
                else if (address_acked)
                begin
                    if (!direction_reg)
                    begin
                        res.send_valid    = 1'b1;
                        res.send_from_mem = index_in_range;
                        mem_req.rd_en     = index_in_range;
                        mem_req.idx       = index_reg;
                        index_next        = index_adv;
                    end
                end
                else if (receive_full)
                begin
                    mem_req.wr_en   = index_in_range;
                    mem_req.idx     = index_reg;
                    mem_req.wr_data = received_byte;
                    index_next      = index_adv;
                    if (rx_last)
                    begin
                        res.request_stop = 1'b1;
                        ack_next         = 1'b0;
                        rx_done_next     = 1'b1;
                    end
                end
                else if (transmit_empty)
                begin
                    if (index_reg == IW'(length_reg))
                    begin
                        res.request_stop = 1'b1;
                        tx_done_next     = 1'b1;
                    end
                    else
                    begin
                        res.send_valid    = 1'b1;
                        res.send_from_mem = index_in_range;
                        mem_req.rd_en     = index_in_range;
                        mem_req.idx       = index_reg;
                        index_next        = index_adv;
                    end
                end
                else if (nack_seen)
                begin
                    err_next = 1'b1;
                end
            end
            i2cm_seq_pkg::CMD_READ:
            begin
                mem_req.rd_en        = bidx_in_range;
                mem_req.idx          = bidx_ext;
                res.readout_from_mem = bidx_in_range;
            end
        endcase
        res.ack_enable    = ack_next;
        res.receive_done  = rx_done_next;
        res.transmit_done = tx_done_next;
        res.nack_error    = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg   <= '0;
            ack_reg     <= 1'b1;
            rx_done_reg <= 1'b0;
            tx_done_reg <= 1'b0;
            err_reg     <= 1'b0;
        end
        else if (accept)
        begin
            index_reg   <= index_next;
            ack_reg     <= ack_next;
            rx_done_reg <= rx_done_next;
            tx_done_reg <= tx_done_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= '0;
            direction_reg     <= 1'b0;
            length_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (i2cm_seq_pkg::cfg_idx_t'(cfg_index))
                i2cm_seq_pkg::CFG_SLAVE_ADDRESS:
                    slave_address_reg <= cfg_data[i2cm_seq_pkg::SADDR_W-1:0];
                i2cm_seq_pkg::CFG_DIRECTION:
                    direction_reg <= cfg_data[0];
                i2cm_seq_pkg::CFG_TRANSFER_LENGTH:
                    length_reg <= cfg_data[i2cm_seq_pkg::LENGTH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> tb/sv/i2c_master_transfer_sequencer_tb.sv
// Self-checking testbench for the I2C master transfer sequencer: directed and random transfers.
`timescale 1ns / 100ps

module i2c_master_transfer_sequencer_tb;

    localparam int BUF_DEPTH   = 16;
    localparam int LATENCY     = 2;
    localparam int RANDOM_OPS  = 1350;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        i2cm_seq_pkg::cmd_t cmd;
        logic [3:0]  bidx;
        logic [7:0]  lval;
        logic        ev_start;
        logic        ev_addr;
        logic        ev_rx;
        logic        ev_tx;
        logic        ev_nack;
        logic [7:0]  rbyte;
    } seq_op_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        request_start;
        logic        request_stop;
        logic        ack_enable;
        logic        receive_done;
        logic        transmit_done;
        logic        nack_error;
        logic [7:0]  readout_byte;
    } seq_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = 2'd0;
    logic [3:0]  buffer_index = 4'd0;
    logic [7:0]  load_value = 8'd0;
    logic        start_sent = 1'b0;
    logic        address_acked = 1'b0;
    logic        receive_full = 1'b0;
    logic        transmit_empty = 1'b0;
    logic        nack_seen = 1'b0;
    logic [7:0]  received_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        request_start;
    logic        request_stop;
    logic        ack_enable;
    logic        receive_done;
    logic        transmit_done;
    logic        nack_error;
    logic [7:0]  readout_byte;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'd0;

    // shadow of the sequencer state and its registers
    logic [7:0]  shadow_buf [BUF_DEPTH];
    logic [7:0]  shadow_index = 8'd0;
    logic        shadow_ack = 1'b1;
    logic        shadow_rx_done = 1'b0;
    logic        shadow_tx_done = 1'b0;
    logic        shadow_err = 1'b0;
    logic [6:0]  cfg_saddr = 7'd0;
    logic        cfg_dir = 1'b0;
    logic [4:0]  cfg_len = 5'd0;

    seq_op_t     pending_q [$];
    seq_resp_t   resp_q [$];
    seq_op_t     drv_op;

    int          queued = 0;
    int          in_transfers = 0;
    int          out_transfers = 0;
    int          cfg_writes = 0;
    int          errors = 0;
    int          cycle_cnt = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;
    int          hold_cnt = 0;
    bit          hold_done = 1'b0;

    i2c_master_transfer_sequencer #(.BUFFER_DEPTH(BUF_DEPTH)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .buffer_index   (buffer_index),
        .load_value     (load_value),
        .start_sent     (start_sent),
        .address_acked  (address_acked),
        .receive_full   (receive_full),
        .transmit_empty (transmit_empty),
        .nack_seen      (nack_seen),
        .received_byte  (received_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .send_valid     (send_valid),
        .send_byte      (send_byte),
        .request_start  (request_start),
        .request_stop   (request_stop),
        .ack_enable     (ack_enable),
        .receive_done   (receive_done),
        .transmit_done  (transmit_done),
        .nack_error     (nack_error),
        .readout_byte   (readout_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit rbit();
        return ($urandom_range(0, 1) == 1);
    endfunction

    function automatic logic [7:0] buf_fetch(logic [7:0] idx);
        if (idx < BUF_DEPTH)
            return shadow_buf[idx];
        return 8'd0;
    endfunction

    function automatic void buf_store(logic [7:0] idx, logic [7:0] val);
        if (idx < BUF_DEPTH)
            shadow_buf[idx] = val;
    endfunction

    function automatic void bump_index();
        if (shadow_index != i2cm_seq_pkg::INDEX_MAX)
            shadow_index = shadow_index + 8'd1;
    endfunction

    function automatic seq_resp_t run_sequencer(seq_op_t op);
        seq_resp_t r;
        r = '0;
        case (op.cmd)
            i2cm_seq_pkg::CMD_LOAD:
                buf_store({4'd0, op.bidx}, op.lval);
            i2cm_seq_pkg::CMD_START:
            begin
                shadow_index = 8'd0;
                shadow_err = 1'b0;
                if (cfg_dir)
                begin
                    shadow_rx_done = 1'b0;
                    shadow_ack = 1'b1;
                end
                else
                    shadow_tx_done = 1'b0;
                r.request_start = 1'b1;
            end
            i2cm_seq_pkg::CMD_EVENT:
            begin
                if (op.ev_start)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte = {cfg_saddr, cfg_dir};
                end
                else if (op.ev_addr)
                begin
                    if (!cfg_dir)
                    begin
                        r.send_valid = 1'b1;
                        r.send_byte = buf_fetch(shadow_index);
                        bump_index();
                    end
                end
                else if (op.ev_rx)
                begin
                    buf_store(shadow_index, op.rbyte);
                    bump_index();
                    if ({1'b0, shadow_index} + 9'd1 == {4'd0, cfg_len})
                    begin
                        r.request_stop = 1'b1;
                        shadow_ack = 1'b0;
                        shadow_rx_done = 1'b1;
                    end
                end
                else if (op.ev_tx)
                begin
                    if (shadow_index == {3'd0, cfg_len})
                    begin
                        r.request_stop = 1'b1;
                        shadow_tx_done = 1'b1;
                    end
                    else
                    begin
                        r.send_valid = 1'b1;
                        r.send_byte = buf_fetch(shadow_index);
                        bump_index();
                    end
                end
                else if (op.ev_nack)
                    shadow_err = 1'b1;
            end
            default:
                r.readout_byte = buf_fetch({4'd0, op.bidx});
        endcase
        r.ack_enable = shadow_ack;
        r.receive_done = shadow_rx_done;
        r.transmit_done = shadow_tx_done;
        r.nack_error = shadow_err;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // driver: bursts of transfers separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                resp_q.push_back(run_sequencer(drv_op));
                in_transfers <= in_transfers + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    drv_op = pending_q.pop_front();
                    cmd <= drv_op.cmd;
                    buffer_index <= drv_op.bidx;
                    load_value <= drv_op.lval;
                    start_sent <= drv_op.ev_start;
                    address_acked <= drv_op.ev_addr;
                    receive_full <= drv_op.ev_rx;
                    transmit_empty <= drv_op.ev_tx;
                    nack_seen <= drv_op.ev_nack;
                    received_byte <= drv_op.rbyte;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result and stall on a changing pattern
    always @(posedge clk or negedge rst_n)
    begin
        seq_resp_t want;
        bit        stall_now;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_transfers++;
                if (resp_q.size() == 0)
                begin
                    $error("result transfer with no expectation pending");
                    errors++;
                end
                else
                begin
                    want = resp_q.pop_front();
                    check_field("send_valid", 8'(want.send_valid), 8'(send_valid));
                    check_field("send_byte", want.send_byte, send_byte);
                    check_field("request_start", 8'(want.request_start), 8'(request_start));
                    check_field("request_stop", 8'(want.request_stop), 8'(request_stop));
                    check_field("ack_enable", 8'(want.ack_enable), 8'(ack_enable));
                    check_field("receive_done", 8'(want.receive_done), 8'(receive_done));
                    check_field("transmit_done", 8'(want.transmit_done), 8'(transmit_done));
                    check_field("nack_error", 8'(want.nack_error), 8'(nack_error));
                    check_field("readout_byte", want.readout_byte, readout_byte);
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (stall_mode)
                0: stall_now = 1'b0;
                1: stall_now = ($urandom_range(0, 3) == 0);
                2: stall_now = rbit();
                default: stall_now = ($urandom_range(0, 9) != 0);
            endcase
            out_stall <= stall_now || (hold_cnt != 0);
        end
    end

    // hold off the output once for a long stretch so the input backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (!hold_done && in_transfers >= HOLD_AFTER)
        begin
            hold_cnt <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic seq_op_t rand_op();
        seq_op_t op;
        op.cmd = i2cm_seq_pkg::cmd_t'($urandom_range(0, 3));
        op.bidx = 4'($urandom_range(0, 15));
        op.lval = 8'($urandom_range(0, 255));
        op.ev_start = rbit();
        op.ev_addr = rbit();
        op.ev_rx = rbit();
        op.ev_tx = rbit();
        op.ev_nack = rbit();
        op.rbyte = 8'($urandom_range(0, 255));
        return op;
    endfunction

    task automatic push_op(seq_op_t op);
        pending_q.push_back(op);
        queued++;
    endtask

    task automatic push_load(logic [3:0] idx, logic [7:0] val);
        seq_op_t op;
        op = rand_op();
        op.cmd = i2cm_seq_pkg::CMD_LOAD;
        op.bidx = idx;
        op.lval = val;
        push_op(op);
    endtask

    task automatic push_start();
        seq_op_t op;
        op = rand_op();
        op.cmd = i2cm_seq_pkg::CMD_START;
        push_op(op);
    endtask

    task automatic push_read(logic [3:0] idx);
        seq_op_t op;
        op = rand_op();
        op.cmd = i2cm_seq_pkg::CMD_READ;
        op.bidx = idx;
        push_op(op);
    endtask

    task automatic push_event(bit s, bit a, bit r, bit t, bit n);
        seq_op_t op;
        op = rand_op();
        op.cmd = i2cm_seq_pkg::CMD_EVENT;
        op.ev_start = s;
        op.ev_addr = a;
        op.ev_rx = r;
        op.ev_tx = t;
        op.ev_nack = n;
        push_op(op);
    endtask

    task automatic write_reg(i2cm_seq_pkg::cfg_idx_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            i2cm_seq_pkg::CFG_SLAVE_ADDRESS:   cfg_saddr = val[6:0];
            i2cm_seq_pkg::CFG_DIRECTION:       cfg_dir = val[0];
            i2cm_seq_pkg::CFG_TRANSFER_LENGTH: cfg_len = val[4:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || resp_q.size() != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic run_transfer();
        int n;
        repeat ($urandom_range(0, 3))
            push_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        push_start();
        push_event(1'b1, rbit(), rbit(), rbit(), rbit());
        push_event(1'b0, 1'b1, rbit(), rbit(), rbit());
        if (!cfg_dir)
            n = (cfg_len == 5'd0) ? 3 : int'(cfg_len);
        else
            n = (cfg_len >= 5'd2) ? int'(cfg_len) - 1 : 2;
        if ($urandom_range(0, 4) == 0)
            n++;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                push_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
                if (rbit())
                    break;
            end
            if (!cfg_dir)
                push_event(1'b0, 1'b0, 1'b0, 1'b1, rbit());
            else
                push_event(1'b0, 1'b0, 1'b1, rbit(), rbit());
        end
        repeat ($urandom_range(0, 3)) push_read(4'($urandom_range(0, 15)));
    endtask

    initial
    begin
        int target;
        int phase;
        int pick;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // write transfer with every flag combination that matters
        write_reg(i2cm_seq_pkg::CFG_SLAVE_ADDRESS, 8'd127);
        write_reg(i2cm_seq_pkg::CFG_DIRECTION, 8'd0);
        write_reg(i2cm_seq_pkg::CFG_TRANSFER_LENGTH, 8'd2);
        for (int i = 0; i < BUF_DEPTH; i++)
            push_load(4'(i), (i == 0) ? 8'h00 : (i == BUF_DEPTH - 1) ? 8'hFF :
                      8'($urandom_range(0, 255)));
        push_start();
        push_event(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        push_event(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        push_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        push_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        push_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        push_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_read(4'd15);
        push_read(4'd0);

        // read transfer of three bytes
        wait_idle();
        write_reg(i2cm_seq_pkg::CFG_SLAVE_ADDRESS, 8'd0);
        write_reg(i2cm_seq_pkg::CFG_DIRECTION, 8'd1);
        write_reg(i2cm_seq_pkg::CFG_TRANSFER_LENGTH, 8'd3);
        push_start();
        push_event(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        push_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_event(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        push_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);

        target = queued + RANDOM_OPS;
        phase = 0;
        while (queued < target)
        begin
            wait_idle();
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                pick = $urandom_range(0, 3);
                write_reg(i2cm_seq_pkg::CFG_SLAVE_ADDRESS,
                          (pick == 0) ? 8'd0 : (pick == 1) ? 8'd127 :
                          8'($urandom_range(0, 127)));
            end
            if (phase == 0 || $urandom_range(0, 2) != 0)
                write_reg(i2cm_seq_pkg::CFG_DIRECTION, 8'($urandom_range(0, 1)));
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                pick = $urandom_range(0, 3);
                write_reg(i2cm_seq_pkg::CFG_TRANSFER_LENGTH,
                          (pick == 0) ? 8'd0 : (pick == 1) ? 8'd16 :
                          8'($urandom_range(1, 16)));
            end
            if (phase == 3)
            begin
                // drive the index into saturation, past the end of the buffer
                push_start();
                repeat (270) push_event(1'b0, 1'b0, 1'b1, rbit(), rbit());
                repeat (3) push_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
                push_event(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
                repeat (4) push_read(4'($urandom_range(0, 15)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 4) != 0)
                        run_transfer();
                    else
                        repeat ($urandom_range(3, 10)) push_op(rand_op());
                end
            end
            phase++;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Checked %0d results from %0d input transfers in %0d phases, %0d register writes.",
                 out_transfers, in_transfers, phase, cfg_writes);
        $display("Covered write and read transfers, nacks, event priority, index saturation.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> i2c_master_transfer_sequencer.f
hdl/i2cm_seq_pkg.sv
hdl/i2cm_seq_buffer.sv
hdl/i2cm_seq_ctrl.sv
hdl/i2c_master_transfer_sequencer.sv
tb/sv/i2c_master_transfer_sequencer_tb.sv
